[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// Define NO_ASSERTIONS to compile every check away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked on every rising clock edge outside reset.
`define SPT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Same check, kept separate for stall related properties.
`define SPT_ASSERT_STALL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("stall assertion failed");
`else
`define SPT_ASSERT(lbl, clk, rst_n, prop)
`define SPT_ASSERT_STALL(lbl, clk, rst_n, prop)
`endif
`endif

[design/spt_pkg.sv]
// ----------------------------------------------------------------------------
// spt_pkg
// Shared constants for the step-toward-target pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package spt_pkg;
  // Default coordinate width (signed Q16.8).
  localparam int COORD_WIDTH_DEF = 24;
  // Extra fraction bits carried on the distance.
  localparam int GUARD_BITS = 7;
endpackage
`default_nettype wire

[design/spt_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// spt_sqrt_pipe
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module spt_sqrt_pipe #(
  parameter int SW     = 33,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire logic [2*SW-1:0]   in_rad,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_vld,
  output logic [SW-1:0]          out_root,
  output logic [SIDE_W-1:0]      out_side
);
  localparam int RW = 2 * SW;

  logic              vld_r  [SW];
  logic [RW-1:0]     rad_r  [SW];
  logic [SW+1:0]     rem_r  [SW];
  logic [SW-1:0]     root_r [SW];
  logic [SIDE_W-1:0] side_r [SW];

  for (genvar i = 0; i < SW; i++) begin : g_stage
    logic              p_vld;
    logic [RW-1:0]     p_rad;
    logic [SW+1:0]     p_rem;
    logic [SW-1:0]     p_root;
    logic [SIDE_W-1:0] p_side;
    logic [SW+1:0]     rem_sh;
    logic [SW+1:0]     trial;
    logic              take;

    if (i == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_rad  = in_rad;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld_r[i-1];
      assign p_rad  = rad_r[i-1];
      assign p_rem  = rem_r[i-1];
      assign p_root = root_r[i-1];
      assign p_side = side_r[i-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {p_rem[SW-1:0], p_rad[RW-1:RW-2]};
    assign trial  = {p_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i]  <= {p_rad[RW-3:0], 2'b00};
        rem_r[i]  <= take ? (rem_sh - trial) : rem_sh;
        root_r[i] <= {p_root[SW-2:0], take};
        side_r[i] <= p_side;
      end
    end
  end

  assign out_vld  = vld_r[SW-1];
  assign out_root = root_r[SW-1];
  assign out_side = side_r[SW-1];
endmodule
`default_nettype wire

[design/spt_div_pipe.sv]
// ----------------------------------------------------------------------------
// spt_div_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module spt_div_pipe #(
  parameter int NW     = 57,
  parameter int QW     = 25,
  parameter int DVW    = 33,
  parameter int SIDE_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire logic [NW-1:0]     in_num,
  input  wire logic [DVW-1:0]    in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_vld,
  output logic [QW-1:0]          out_quo,
  output logic [SIDE_W-1:0]      out_side
);
  logic              vld_r  [QW];
  logic [QW-1:0]     low_r  [QW];
  logic [DVW:0]      rem_r  [QW];
  logic [QW-1:0]     quo_r  [QW];
  logic [DVW-1:0]    den_r  [QW];
  logic [SIDE_W-1:0] side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic              p_vld;
    logic [QW-1:0]     p_low;
    logic [DVW:0]      p_rem;
    logic [QW-1:0]     p_quo;
    logic [DVW-1:0]    p_den;
    logic [SIDE_W-1:0] p_side;
    logic [DVW:0]      rem_sh;
    logic              take;

    if (i == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_low  = in_num[QW-1:0];
      assign p_rem  = (DVW+1)'(in_num[NW-1:QW]);
      assign p_quo  = '0;
      assign p_den  = in_den;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld_r[i-1];
      assign p_low  = low_r[i-1];
      assign p_rem  = rem_r[i-1];
      assign p_quo  = quo_r[i-1];
      assign p_den  = den_r[i-1];
      assign p_side = side_r[i-1];
    end

    // Shift in one numerator bit and subtract the divisor when it fits.
    assign rem_sh = {p_rem[DVW-1:0], p_low[QW-1]};
    assign take   = (rem_sh >= {1'b0, p_den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        low_r[i]  <= p_low << 1;
        rem_r[i]  <= take ? (rem_sh - {1'b0, p_den}) : rem_sh;
        quo_r[i]  <= {p_quo[QW-2:0], take};
        den_r[i]  <= p_den;
        side_r[i] <= p_side;
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];
endmodule
`default_nettype wire

[design/step_point_toward_target.sv]
// ----------------------------------------------------------------------------
// step_point_toward_target
// Moves a point a given distance along the line toward a target point.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in_      in   tdata: start_x, start_y, target_x, target_y, step_dist
// out_     out  tdata: new_x, new_y; tuser: reached
//
// One request enters per cycle while the output is not held; the pipeline has
// 3 front stages, COORD_WIDTH+9 square root stages, one rounding stage,
// COORD_WIDTH+1 divider stages and one output register.
// All stages advance together; a held output freezes the whole pipeline.
// Reset clears the valid bits only.
`default_nettype none
`include "assert_macros.svh"
module step_point_toward_target #(
  parameter int COORD_WIDTH = spt_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // start_x, start_y, target_x, target_y, step_dist (lowest first)
  input  wire logic [((5*COORD_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // new_x, new_y (lowest first)
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]        out_tdata,
  // reached
  output logic                                      out_tuser
);
  localparam int W   = COORD_WIDTH;
  localparam int G   = spt_pkg::GUARD_BITS;
  localparam int DW  = W + 1;
  localparam int SW  = W + 9;
  localparam int RW  = 2 * SW;
  localparam int PW  = DW + W;
  localparam int NW  = 2 * W + 9;
  localparam int QW  = W + 1;
  localparam int OTW = ((2*COORD_WIDTH+7)/8)*8;
  localparam int SQ_SIDE = 3 + 4*W + 2*PW;
  localparam int XS_W    = 2 + 2*W;
  localparam int YS_W    = 1 + 2*W;

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Stage A: unpack and form the differences.
  logic                a_vld_r;
  logic signed [W-1:0] a_sx_r, a_sy_r, a_tx_r, a_ty_r;
  logic [W-1:0]        a_step_r;
  logic signed [DW-1:0] a_dx_r, a_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sx_r   <= in_tdata[W-1:0];
      a_sy_r   <= in_tdata[2*W-1:W];
      a_tx_r   <= in_tdata[3*W-1:2*W];
      a_ty_r   <= in_tdata[4*W-1:3*W];
      a_step_r <= in_tdata[5*W-1:4*W];
      a_dx_r   <= DW'($signed(in_tdata[3*W-1:2*W])) - DW'($signed(in_tdata[W-1:0]));
      a_dy_r   <= DW'($signed(in_tdata[4*W-1:3*W])) - DW'($signed(in_tdata[2*W-1:W]));
    end
  end

  // Stage B: magnitudes squared and scaled by the step, and the step squared.
  logic [DW-1:0] a_ax, a_ay;
  assign a_ax = a_dx_r[DW-1] ? DW'(-a_dx_r) : DW'(a_dx_r);
  assign a_ay = a_dy_r[DW-1] ? DW'(-a_dy_r) : DW'(a_dy_r);

  logic                b_vld_r, b_sgx_r, b_sgy_r;
  logic [W-1:0]        b_sx_r, b_sy_r, b_tx_r, b_ty_r;
  logic [2*DW-1:0]     b_ax2_r, b_ay2_r;
  logic [2*W-1:0]      b_ss_r;
  logic [PW-1:0]       b_px_r, b_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sgx_r <= a_dx_r[DW-1];
      b_sgy_r <= a_dy_r[DW-1];
      b_sx_r  <= a_sx_r;
      b_sy_r  <= a_sy_r;
      b_tx_r  <= a_tx_r;
      b_ty_r  <= a_ty_r;
      b_ax2_r <= (2*DW)'(a_ax) * (2*DW)'(a_ax);
      b_ay2_r <= (2*DW)'(a_ay) * (2*DW)'(a_ay);
      b_ss_r  <= (2*W)'(a_step_r) * (2*W)'(a_step_r);
      b_px_r  <= PW'(a_ax) * PW'(a_step_r);
      b_py_r  <= PW'(a_ay) * PW'(a_step_r);
    end
  end

  // Stage C: squared distance and the reach test.
  logic [2*DW:0] b_d2;
  assign b_d2 = (2*DW+1)'(b_ax2_r) + (2*DW+1)'(b_ay2_r);

  logic               c_vld_r, c_reach_r;
  logic [RW-1:0]      c_rad_r;
  logic [SQ_SIDE-2:0] c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_reach_r <= (b_d2 <= (2*DW+1)'(b_ss_r));
      c_rad_r   <= RW'({b_d2, {(2*G){1'b0}}});
      c_side_r  <= {b_sgx_r, b_sgy_r, b_sx_r, b_sy_r, b_tx_r, b_ty_r, b_px_r, b_py_r};
    end
  end

  // Distance with guard bits.
  logic               sq_vld;
  logic [SW-1:0]      sq_root;
  logic [SQ_SIDE-1:0] sq_side;

  spt_sqrt_pipe #(
    .SW     (SW),
    .SIDE_W (SQ_SIDE)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (c_vld_r),
    .in_rad   (c_rad_r),
    .in_side  ({c_reach_r, c_side_r}),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  // Stage E: rounding numerators; a zero distance becomes one.
  logic          sq_reach, sq_sgx, sq_sgy;
  logic [W-1:0]  sq_sx, sq_sy, sq_tx, sq_ty;
  logic [PW-1:0] sq_px, sq_py;
  logic [SW-1:0] sq_den;
  assign {sq_reach, sq_sgx, sq_sgy, sq_sx, sq_sy, sq_tx, sq_ty, sq_px, sq_py} = sq_side;
  assign sq_den = (sq_root == '0) ? SW'(1) : sq_root;

  logic              e_vld_r;
  logic [NW-1:0]     e_numx_r, e_numy_r;
  logic [SW-1:0]     e_den_r;
  logic [XS_W-1:0]   e_xside_r;
  logic [YS_W-1:0]   e_yside_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_numx_r  <= NW'({sq_px, {G{1'b0}}}) + NW'(sq_den >> 1);
      e_numy_r  <= NW'({sq_py, {G{1'b0}}}) + NW'(sq_den >> 1);
      e_den_r   <= sq_den;
      e_xside_r <= {sq_reach, sq_sgx, sq_sx, sq_tx};
      e_yside_r <= {sq_sgy, sq_sy, sq_ty};
    end
  end

  // Offsets along each axis.
  logic            dx_vld, dy_vld;
  logic [QW-1:0]   qx, qy;
  logic [XS_W-1:0] xside;
  logic [YS_W-1:0] yside;

  spt_div_pipe #(
    .NW (NW), .QW (QW), .DVW (SW), .SIDE_W (XS_W)
  ) u_div_x (
    .clk (clk), .rst_n (rst_n), .en (adv),
    .in_vld (e_vld_r), .in_num (e_numx_r), .in_den (e_den_r), .in_side (e_xside_r),
    .out_vld (dx_vld), .out_quo (qx), .out_side (xside)
  );

  spt_div_pipe #(
    .NW (NW), .QW (QW), .DVW (SW), .SIDE_W (YS_W)
  ) u_div_y (
    .clk (clk), .rst_n (rst_n), .en (adv),
    .in_vld (e_vld_r), .in_num (e_numy_r), .in_den (e_den_r), .in_side (e_yside_r),
    .out_vld (dy_vld), .out_quo (qy), .out_side (yside)
  );

  // Output stage: apply the signed offsets or return the target.
  logic          f_reach, f_sgx, f_sgy;
  logic [W-1:0]  f_sx, f_tx, f_sy, f_ty;
  logic [W+1:0]  offx, offy;
  logic [W-1:0]  nx, ny;
  assign {f_reach, f_sgx, f_sx, f_tx} = xside;
  assign {f_sgy, f_sy, f_ty}          = yside;
  assign offx = f_sgx ? (W+2)'(-(W+2)'(qx)) : (W+2)'(qx);
  assign offy = f_sgy ? (W+2)'(-(W+2)'(qy)) : (W+2)'(qy);
  assign nx   = W'((W+2)'($signed(f_sx)) + offx);
  assign ny   = W'((W+2)'($signed(f_sy)) + offy);

  logic         o_vld_r, o_reach_r;
  logic [W-1:0] o_x_r, o_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= dx_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_reach_r <= f_reach;
      o_x_r     <= f_reach ? f_tx : nx;
      o_y_r     <= f_reach ? f_ty : ny;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = OTW'({o_y_r, o_x_r});
  assign out_tuser  = o_reach_r;

  // Checks on the pipeline.
  `SPT_ASSERT(a_ready_rule, clk, rst_n, in_tready == (!out_tvalid || out_tready))
  `SPT_ASSERT(a_div_lockstep, clk, rst_n, dx_vld == dy_vld)
  `SPT_ASSERT(a_dist_nonzero, clk, rst_n, (sq_vld && !sq_reach) |-> (sq_root != '0))
  `SPT_ASSERT_STALL(a_stall_hold, clk, rst_n, !adv |=> $stable(e_vld_r))
endmodule
`default_nettype wire

[bench/step_point_toward_target_test.sv]
// ----------------------------------------------------------------------------
// step_point_toward_target_test
// Drives start/target/step requests into the block with random gaps and
// output stalls, predicts every result with an exact integer model, and
// compares each returned point and reached flag in order.
// ----------------------------------------------------------------------------
`default_nettype none
module step_point_toward_target_test;
  localparam int CW = spt_pkg::COORD_WIDTH_DEF;
  localparam int GB = spt_pkg::GUARD_BITS;
  localparam int IN_W = ((5*CW+7)/8)*8;
  localparam int OUT_W = ((2*CW+7)/8)*8;
  localparam int LATENCY = 2*CW + 15;
  localparam int N_RANDOM = 1930;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [CW-1:0] nx;
    logic signed [CW-1:0] ny;
    logic                 reached;
  } point_t;

  // Expected moved points, oldest first, plus the exact move calculation.
  class point_scoreboard;
    point_t pending[$];
    int     errors;
    int     checked;
    int     reached_cnt;

    // Integer square root of a 128-bit value, truncated.
    function automatic logic [63:0] isqrt(logic [127:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (128'(c) * 128'(c) <= v) r = c;
      end
      return r;
    endfunction

    // Offset along one axis, rounded to nearest, clamped to |delta|.
    function automatic longint axis_offset(longint delta, logic [63:0] step,
                                           logic [63:0] root_len);
      logic [127:0] mag;
      logic [127:0] q;
      mag = (delta < 0) ? 128'(-delta) : 128'(delta);
      q = (((mag * 128'(step)) << GB) + 128'(root_len >> 1)) / 128'(root_len);
      if (q > mag) q = mag;
      return (delta < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void note_request(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                               logic signed [CW-1:0] tx, logic signed [CW-1:0] ty,
                               logic [CW-1:0] step);
      longint dx;
      longint dy;
      logic [127:0] d2;
      logic [63:0] root_len;
      point_t p;
      dx = longint'(tx) - longint'(sx);
      dy = longint'(ty) - longint'(sy);
      d2 = 128'(dx * dx) + 128'(dy * dy);
      if (d2 <= 128'(step) * 128'(step)) begin
        p.nx = tx;
        p.ny = ty;
        p.reached = 1'b1;
      end else begin
        root_len = isqrt(d2 << (2*GB));
        if (root_len == 0) root_len = 1;
        p.nx = CW'(longint'(sx) + axis_offset(dx, 64'(step), root_len));
        p.ny = CW'(longint'(sy) + axis_offset(dy, 64'(step), root_len));
        p.reached = 1'b0;
      end
      pending.push_back(p);
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic user);
      point_t want;
      point_t got;
      got.nx = data[CW-1:0];
      got.ny = data[2*CW-1:CW];
      got.reached = user;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d reached=%0b", $time,
                 got.nx, got.ny, got.reached);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.reached) reached_cnt++;
      if (got.nx !== want.nx) begin
        $display("%0t: new_x expected %0d actual %0d", $time, want.nx, got.nx);
        errors++;
      end
      if (got.ny !== want.ny) begin
        $display("%0t: new_y expected %0d actual %0d", $time, want.ny, got.ny);
        errors++;
      end
      if (got.reached !== want.reached) begin
        $display("%0t: reached expected %0b actual %0b", $time, want.reached,
                 got.reached);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;

  point_scoreboard board = new();
  bit sending_done = 1'b0;
  bit rx_calm = 1'b0;
  int idle_cycles = 0;
  int sent = 0;

  always #5 clk = ~clk;

  step_point_toward_target u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Send one request after a random gap, and note it once accepted.
  task automatic send_move(logic [CW-1:0] sx, logic [CW-1:0] sy,
                           logic [CW-1:0] tx, logic [CW-1:0] ty,
                           logic [CW-1:0] step);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= IN_W'({step, ty, tx, sy, sx});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_request(sx, sy, tx, ty, step);
    sent++;
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 4000)) - 2000);
      2: return ($urandom_range(0, 1)) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      default: return CW'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
    endcase
  endfunction

  // Result side: random stall before each result, sometimes none at all.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
      if (rx_calm) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 15) == 0) ||
                         ($urandom_range(0, 15) >= $urandom_range(0, 15));
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] st;
    logic [CW-1:0] maxp;
    logic [CW-1:0] minn;
    maxp = {1'b0, {(CW-1){1'b1}}};
    minn = {1'b1, {(CW-1){1'b0}}};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: identical points, zero step, axis-aligned lines, extremes.
    send_move('0, '0, '0, '0, '0);
    send_move(maxp, minn, maxp, minn, '0);
    send_move('0, '0, CW'(1000), CW'(-500), '0);
    send_move('0, '0, CW'(2560), '0, CW'(256));
    send_move('0, CW'(100), '0, CW'(-900), CW'(300));
    send_move(CW'(7), '0, CW'(7), CW'(50), CW'(50));
    send_move(CW'(7), '0, CW'(7), CW'(51), CW'(50));
    send_move(CW'(768), CW'(1024), '0, '0, CW'(1280));
    send_move(minn, minn, maxp, maxp, '1);
    send_move(minn, minn, maxp, maxp, CW'(1));
    send_move(maxp, maxp, minn, minn, CW'(12345));
    send_move(minn, maxp, maxp, minn, {1'b1, {(CW-1){1'b0}}});
    send_move(maxp, '0, minn, '0, maxp);
    send_move('0, '0, CW'(1), CW'(1), CW'(1));
    send_move('0, '0, CW'(3), CW'(4), CW'(4));
    send_move('0, '0, CW'(-3), CW'(-4), CW'(2));
    send_move('1, '1, '0, '0, '0);
    send_move(CW'(5), CW'(5), CW'(-5), CW'(5), CW'(3));
    // Pause until every expected result has come.
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    // Random part with a short calm stretch in which the output is always ready.
    for (int i = 0; i < N_RANDOM; i++) begin
      rx_calm = (i >= 400 && i < 500);
      sx = rand_coord();
      sy = rand_coord();
      case ($urandom_range(0, 5))
        0: st = CW'($urandom);
        1: st = '0;
        2: st = '1;
        default: st = CW'($urandom_range(0, 1 << 14));
      endcase
      if ($urandom_range(0, 19) == 0) send_move(sx, sy, sx, sy, st);
      else send_move(sx, sy, rand_coord(), rand_coord(), st);
    end
    rx_calm = 1'b0;
    in_tvalid <= 1'b0;
    sending_done = 1'b1;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d move requests; checked %0d results, %0d reached the target.",
             sent, board.checked, board.reached_cnt);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
